### rtl/core/apsp_pkg.sv
// Shared types and constants of the all-pairs shortest path block.
// Holds the opcodes, the result kinds and the microcode table of the sequencer.
// No dependencies.
package apsp_pkg;

  // Opcodes of an input word
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Kinds of a result word
  localparam logic RK_DONE = 1'b0;
  localparam logic RK_READ = 1'b1;

  // Microprogram addresses
  localparam int UPC_W = 3;
  localparam logic [UPC_W-1:0] U_IDLE  = 3'd0;
  localparam logic [UPC_W-1:0] U_READ  = 3'd1;
  localparam logic [UPC_W-1:0] U_ROW   = 3'd2;
  localparam logic [UPC_W-1:0] U_LOAD  = 3'd3;
  localparam logic [UPC_W-1:0] U_SWEEP = 3'd4;
  localparam logic [UPC_W-1:0] U_NEXT  = 3'd5;
  localparam logic [UPC_W-1:0] U_DONE  = 3'd6;

  // Sequencing modes
  localparam logic [1:0] JM_ALW  = 2'd0; // go to target
  localparam logic [1:0] JM_IF   = 2'd1; // target if condition, else fall through
  localparam logic [1:0] JM_WAIT = 2'd2; // target if condition, else hold
  localparam logic [1:0] JM_DISP = 2'd3; // dispatch on the accepted opcode

  // Jump conditions
  localparam logic [1:0] C_OUT_FREE  = 2'd0;
  localparam logic [1:0] C_LAST_J    = 2'd1;
  localparam logic [1:0] C_MORE_ROWS = 2'd2;

  typedef struct packed {
    logic             in_rdy;    // take an input word
    logic             rd_row;    // fetch d[i][k], restart the column count
    logic             rd_cell;   // fetch d[k][j] and d[i][j]
    logic             j_step;    // advance the column count
    logic             latch_dik; // capture d[i][k]
    logic             relax;     // compare and write back d[i][j]
    logic             ld_out;    // load the result register when free
    logic             out_kind;  // kind of the loaded result
    logic             advance;   // step to the next row, or the next pivot
    logic [1:0]       jmode;
    logic [1:0]       cond;
    logic [UPC_W-1:0] target;
  } apsp_uword_t;

  // Control store: one word per step
  function automatic apsp_uword_t apsp_ucode(input logic [UPC_W-1:0] pc);
    apsp_uword_t w;
    w = '0;
    case (pc)
      U_IDLE: begin
        w.in_rdy = 1'b1;
        w.jmode  = JM_DISP;
      end
      U_READ: begin
        w.ld_out   = 1'b1;
        w.out_kind = RK_READ;
        w.jmode    = JM_WAIT;
        w.cond     = C_OUT_FREE;
        w.target   = U_IDLE;
      end
      U_ROW: begin
        w.rd_row = 1'b1;
        w.jmode  = JM_ALW;
        w.target = U_LOAD;
      end
      U_LOAD: begin
        w.latch_dik = 1'b1;
        w.rd_cell   = 1'b1;
        w.jmode     = JM_ALW;
        w.target    = U_SWEEP;
      end
      U_SWEEP: begin
        w.relax   = 1'b1;
        w.rd_cell = 1'b1;
        w.j_step  = 1'b1;
        w.jmode   = JM_WAIT;
        w.cond    = C_LAST_J;
        w.target  = U_NEXT;
      end
      U_NEXT: begin
        w.advance = 1'b1;
        w.jmode   = JM_IF;
        w.cond    = C_MORE_ROWS;
        w.target  = U_ROW;
      end
      U_DONE: begin
        w.ld_out   = 1'b1;
        w.out_kind = RK_DONE;
        w.jmode    = JM_WAIT;
        w.cond     = C_OUT_FREE;
        w.target   = U_IDLE;
      end
      default: begin
        w.jmode  = JM_ALW;
        w.target = U_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

### rtl/core/apsp_ram.sv
// Generic simple dual-port RAM: one write port, two read ports.
// Read data is registered and holds while its read enable is low.
// No dependencies.
module apsp_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [DATA_W-1:0]        rdata_a,
  input  logic                     re_b,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [DATA_W-1:0]        rdata_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read ports
  always_ff @(posedge clk) begin
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

### rtl/core/all_pairs_shortest_path_top.sv
// All-pairs shortest path block: distance matrix store with in-place relaxation.
// Depends on apsp_pkg (microcode table, codes) and apsp_ram (matrix store).
//
// The block keeps a MAX_NODES by MAX_NODES matrix of signed WEIGHT_BITS distances
// in one RAM. A write word stores one entry; a read word loads the entry into the
// result register once that register is free, with the matrix value saturated to
// 16 bits (zero for an index beyond MAX_NODES). A run word relaxes the matrix in
// place over the first node_count nodes, pivot outermost, then row, then column,
// and gives one done result. The single RAM write port retires one relaxation a
// cycle, with the row set-up steps U_ROW, U_LOAD and U_NEXT in between. Path sums
// saturate to the weight range; equal sums keep the stored entry. Entries are
// undefined until written. The user must write node_count only while the block is
// idle; the block itself does not enforce it. node_count saturates to MAX_NODES.
// The input side takes a new word whenever the sequencer is idle, even while a
// result word still waits.
module all_pairs_shortest_path_top
  import apsp_pkg::*;
#(
  parameter int MAX_NODES   = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // Configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         cfg_node_count,
  // Input words
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic [3:0]         in_row,
  input  logic [3:0]         in_col,
  input  logic signed [15:0] in_weight,
  // Result words
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_result_kind,
  output logic signed [15:0] out_distance
);

  localparam int IW    = $clog2(MAX_NODES);
  localparam int NW    = $clog2(MAX_NODES + 1);
  localparam int CELLS = MAX_NODES * MAX_NODES;
  localparam int AW    = $clog2(CELLS);
  localparam int WB    = WEIGHT_BITS;
  localparam int XW    = ((WEIGHT_BITS > 16) ? WEIGHT_BITS : 16) + 1;

  localparam logic signed [XW-1:0] W_MAX_X = XW'((64'sd1 <<< (WEIGHT_BITS - 1)) - 64'sd1);
  localparam logic signed [XW-1:0] W_MIN_X = ~W_MAX_X;
  localparam logic signed [XW-1:0] D_MAX_X = XW'(32767);
  localparam logic signed [XW-1:0] D_MIN_X = ~D_MAX_X;

  function automatic logic signed [XW-1:0] clamp_x(input logic signed [XW-1:0] v,
                                                   input logic signed [XW-1:0] lo,
                                                   input logic signed [XW-1:0] hi);
    logic signed [XW-1:0] r;
    r = v;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [AW-1:0] r,
                                              input logic [AW-1:0] c);
    return AW'(r * MAX_NODES + c);
  endfunction

  apsp_uword_t uw;

  logic [UPC_W-1:0]       pc_r, pc_nxt;
  logic [IW-1:0]          k_r, k_nxt;
  logic [IW-1:0]          i_r, i_nxt;
  logic [IW-1:0]          j_r, j_nxt;
  logic [IW-1:0]          j_rd;
  logic signed [WB-1:0]   dik_r, dik_nxt;
  logic [4:0]             node_count_r;
  logic                   rd_in_r;
  logic                   out_valid_r;
  logic                   out_kind_r;
  logic signed [15:0]     out_distance_r;

  logic [NW-1:0]          n_eff;
  logic [NW-1:0]          n_last;
  logic                   last_i, last_j, last_k;
  logic                   out_free;
  logic                   cond_hit;
  logic                   accept;
  logic                   in_inside;
  logic [AW-1:0]          in_addr;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [WB-1:0]          ram_wdata;
  logic                   ram_re_a, ram_re_b;
  logic [AW-1:0]          ram_raddr_a, ram_raddr_b;
  logic [WB-1:0]          ram_rdata_a, ram_rdata_b;

  logic signed [WB-1:0]   dkj, dij;
  logic signed [XW-1:0]   sum_x;
  logic signed [WB-1:0]   via;
  logic                   take;
  logic signed [WB-1:0]   in_w_sat;
  logic signed [15:0]     rd_sat;

  // Decode the current control word
  assign uw = apsp_ucode(pc_r);

  // Handshakes
  assign cfg_ready       = 1'b1;
  assign in_ready        = uw.in_rdy;
  assign accept          = in_valid && uw.in_rdy;
  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_distance    = out_distance_r;
  assign out_free        = !out_valid_r || out_ready;

  // Effective node count and loop bounds
  assign n_eff  = (32'(node_count_r) > MAX_NODES) ? NW'(MAX_NODES) : NW'(node_count_r);
  assign n_last = n_eff - 1'b1;
  assign last_i = (NW'(i_r) == n_last);
  assign last_j = (NW'(j_r) == n_last);
  assign last_k = (NW'(k_r) == n_last);

  // Input word address
  assign in_inside = (32'(in_row) < MAX_NODES) && (32'(in_col) < MAX_NODES);
  assign in_addr   = cell_addr(AW'(in_row), AW'(in_col));

  // Select the jump condition
  always_comb begin
    case (uw.cond)
      C_OUT_FREE:  cond_hit = out_free;
      C_LAST_J:    cond_hit = last_j;
      C_MORE_ROWS: cond_hit = !(last_i && last_k);
      default:     cond_hit = 1'b0;
    endcase
  end

  // Next step of the microprogram
  always_comb begin
    pc_nxt = pc_r;
    case (uw.jmode)
      JM_ALW:  pc_nxt = uw.target;
      JM_IF:   pc_nxt = cond_hit ? uw.target : pc_r + 1'b1;
      JM_WAIT: pc_nxt = cond_hit ? uw.target : pc_r;
      JM_DISP: begin
        if (accept) begin
          case (in_opcode)
            OP_READ: pc_nxt = U_READ;
            OP_RUN:  pc_nxt = (n_eff == '0) ? U_DONE : U_ROW;
            default: pc_nxt = pc_r;
          endcase
        end
      end
      default: pc_nxt = U_IDLE;
    endcase
  end

  // Column index of the fetch issued this cycle
  assign j_rd = uw.j_step ? j_r + 1'b1 : j_r;

  // Relaxation datapath: saturated path sum, compare against the stored entry
  assign dkj   = $signed(ram_rdata_a);
  assign dij   = $signed(ram_rdata_b);
  assign sum_x = XW'(dik_r) + XW'(dkj);
  assign via   = WB'(clamp_x(sum_x, W_MIN_X, W_MAX_X));
  assign take  = uw.relax && (via < dij);

  // Saturate the written weight and the read-back entry
  assign in_w_sat = WB'(clamp_x(XW'(in_weight), W_MIN_X, W_MAX_X));
  assign rd_sat   = 16'(clamp_x(XW'($signed(ram_rdata_a)), D_MIN_X, D_MAX_X));

  // RAM ports
  always_comb begin
    ram_we    = take || (accept && (in_opcode == OP_WRITE) && in_inside);
    ram_waddr = uw.relax ? cell_addr(AW'(i_r), AW'(j_r)) : in_addr;
    ram_wdata = uw.relax ? via : in_w_sat;

    ram_re_a    = uw.rd_row || uw.rd_cell || (accept && (in_opcode == OP_READ));
    ram_raddr_a = in_addr;
    if (uw.rd_row) begin
      ram_raddr_a = cell_addr(AW'(i_r), AW'(k_r));
    end else if (uw.rd_cell) begin
      ram_raddr_a = cell_addr(AW'(k_r), AW'(j_rd));
    end
    ram_re_b    = uw.rd_cell;
    ram_raddr_b = cell_addr(AW'(i_r), AW'(j_rd));
  end

  apsp_ram #(
    .DATA_W (WB),
    .DEPTH  (CELLS)
  ) u_matrix (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re_a    (ram_re_a),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .re_b    (ram_re_b),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  // Loop counters and the held d[i][k]
  always_comb begin
    k_nxt   = k_r;
    i_nxt   = i_r;
    j_nxt   = j_r;
    dik_nxt = dik_r;
    if (accept && (in_opcode == OP_RUN)) begin
      k_nxt = '0;
      i_nxt = '0;
    end
    if (uw.rd_row) begin
      j_nxt = '0;
    end
    if (uw.j_step) begin
      j_nxt = j_r + 1'b1;
    end
    if (uw.advance) begin
      if (last_i) begin
        i_nxt = '0;
        k_nxt = k_r + 1'b1;
      end else begin
        i_nxt = i_r + 1'b1;
      end
    end
    // refresh d[i][k] when the sweep rewrites it
    if (uw.latch_dik) begin
      dik_nxt = $signed(ram_rdata_a);
    end else if (take && (j_r == k_r)) begin
      dik_nxt = via;
    end
  end

  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    dik_r <= dik_nxt;
    if (accept && (in_opcode == OP_READ)) begin
      rd_in_r <= in_inside;
    end
  end

  // Sequencer and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= U_IDLE;
      node_count_r <= 5'd16;
    end else begin
      pc_r <= pc_nxt;
      if (cfg_valid) begin
        node_count_r <= cfg_node_count;
      end
    end
  end

  // Result register: load a word, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (uw.ld_out && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.ld_out && out_free) begin
      out_kind_r     <= uw.out_kind;
      out_distance_r <= ((uw.out_kind == RK_READ) && rd_in_r) ? rd_sat : 16'sd0;
    end
  end

  // A read word always moves to the read-back step
  a_read_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_opcode == OP_READ)) |=> (pc_r == U_READ))
    else $error("read word not followed by read-back step");

  // The column count never runs past the last node while sweeping
  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == U_SWEEP) |-> (NW'(j_r) <= n_last))
    else $error("column count beyond node count");

  // Pivot and row stay within the node count during the relaxation
  a_loop_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((pc_r == U_ROW) || (pc_r == U_LOAD) || (pc_r == U_SWEEP) || (pc_r == U_NEXT))
    |-> ((NW'(k_r) < n_eff) && (NW'(i_r) < n_eff)))
    else $error("pivot or row beyond node count");

  // A done word carries a zero distance
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == RK_DONE)) |-> (out_distance_r == 16'sd0))
    else $error("done word with non-zero distance");

  // No relaxation write-back outside the sweep step
  a_relax_only_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> (pc_r == U_SWEEP))
    else $error("relaxation write outside sweep");

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Testbench for all_pairs_shortest_path_top: directed script, then random words under idling.
// Depends on apsp_pkg for opcodes and result kinds, and on the block's RTL only.
module tb;
  import apsp_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int NODES = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct packed {
    logic        kind;
    logic [15:0] distance;
  } path_result_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [15:0] weight;
    logic        typed;
    logic        kind;
    logic [15:0] distance;
  } script_step_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [4:0]         cfg_node_count;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_opcode;
  logic [3:0]         in_row;
  logic [3:0]         in_col;
  logic signed [15:0] in_weight;
  logic               out_valid;
  logic               out_ready;
  logic               out_result_kind;
  logic signed [15:0] out_distance;

  // Predictor state: its own copy of the matrix and of node_count
  logic signed [15:0] dist_model [NODES][NODES];
  logic [4:0]         nodes_model;
  path_result_t       pending_results [$];
  bit                 written_mask [NODES][NODES];
  bit                 typed_pending;
  path_result_t       typed_result;

  int errors = 0;
  int stall_cycles = 0;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_off_req = 1'b0;

  // Directed script over three nodes; typed rows carry their own expectation
  script_step_t script [22] = '{
    '{OP_WRITE,  4'd0,  4'd0,  16'h0000, 1'b0, RK_DONE, 16'h0000},
    '{OP_WRITE,  4'd0,  4'd1,  16'h7FFF, 1'b0, RK_DONE, 16'h0000},
    '{OP_WRITE,  4'd0,  4'd2,  16'd5,    1'b0, RK_DONE, 16'h0000},
    '{OP_WRITE,  4'd1,  4'd0,  16'd7,    1'b0, RK_DONE, 16'h0000},
    '{OP_WRITE,  4'd1,  4'd1,  16'h0000, 1'b0, RK_DONE, 16'h0000},
    '{OP_WRITE,  4'd1,  4'd2,  16'h7FFF, 1'b0, RK_DONE, 16'h0000},
    '{OP_WRITE,  4'd2,  4'd0,  16'h7FFF, 1'b0, RK_DONE, 16'h0000},
    '{OP_WRITE,  4'd2,  4'd1,  16'd3,    1'b0, RK_DONE, 16'h0000},
    '{OP_WRITE,  4'd2,  4'd2,  16'h0000, 1'b0, RK_DONE, 16'h0000},
    '{OP_READ,   4'd0,  4'd1,  16'h0000, 1'b1, RK_READ, 16'h7FFF},
    '{OP_READ,   4'd2,  4'd1,  16'h0000, 1'b1, RK_READ, 16'd3},
    '{OP_RUN,    4'd0,  4'd0,  16'h0000, 1'b1, RK_DONE, 16'h0000},
    '{OP_READ,   4'd0,  4'd1,  16'h0000, 1'b0, RK_DONE, 16'h0000},
    '{OP_READ,   4'd1,  4'd2,  16'h0000, 1'b0, RK_DONE, 16'h0000},
    '{OP_READ,   4'd2,  4'd0,  16'h0000, 1'b0, RK_DONE, 16'h0000},
    '{OP_UNUSED, 4'd15, 4'd15, 16'hFFFF, 1'b0, RK_DONE, 16'h0000},
    '{OP_WRITE,  4'd15, 4'd15, 16'h8000, 1'b0, RK_DONE, 16'h0000},
    '{OP_READ,   4'd15, 4'd15, 16'h0000, 1'b1, RK_READ, 16'h8000},
    '{OP_WRITE,  4'd1,  4'd1,  16'h8000, 1'b0, RK_DONE, 16'h0000},
    '{OP_RUN,    4'd9,  4'd6,  16'hA5A5, 1'b1, RK_DONE, 16'h0000},
    '{OP_READ,   4'd0,  4'd0,  16'h0000, 1'b0, RK_DONE, 16'h0000},
    '{OP_READ,   4'd2,  4'd2,  16'h0000, 1'b0, RK_DONE, 16'h0000}
  };

  all_pairs_shortest_path_top #(
    .MAX_NODES  (NODES),
    .WEIGHT_BITS(16)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_node_count (cfg_node_count),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_row         (in_row),
    .in_col         (in_col),
    .in_weight      (in_weight),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result_kind(out_result_kind),
    .out_distance   (out_distance)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Relax the predicted matrix in place: pivot, then row, then column, sums saturated
  task automatic relax_model();
    int n;
    int s;
    n = (nodes_model > NODES) ? NODES : int'(nodes_model);
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < n; j++) begin
          s = int'(dist_model[i][k]) + int'(dist_model[k][j]);
          if (s > 32767) s = 32767;
          else if (s < -32768) s = -32768;
          // equal sums keep the stored entry
          if (s < int'(dist_model[i][j])) dist_model[i][j] = s[15:0];
        end
      end
    end
  endtask

  // Check result words, predict on accepted input words, watch for a hang
  always @(posedge clk) begin : monitor
    path_result_t want;
    path_result_t predicted;
    bit has_result;
    if (!rst_n) begin
      nodes_model = 5'd16;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected: result_kind %0d distance %0d",
                 out_result_kind, out_distance);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_result_kind !== want.kind) begin
            $error("result_kind: expected %0d, actual %0d", want.kind, out_result_kind);
            errors++;
          end
          if (out_distance !== want.distance) begin
            $error("distance: expected %0d, actual %0d", $signed(want.distance),
                   out_distance);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) nodes_model = cfg_node_count;
      if (in_valid && in_ready) begin
        predicted.kind = RK_READ;
        predicted.distance = '0;
        has_result = 1'b0;
        case (in_opcode)
          OP_WRITE: dist_model[in_row][in_col] = in_weight;
          OP_RUN: begin
            relax_model();
            predicted.kind = RK_DONE;
            has_result = 1'b1;
          end
          OP_READ: begin
            predicted.distance = dist_model[in_row][in_col];
            has_result = 1'b1;
          end
          default: ; // unused opcode: drop
        endcase
        if (has_result) pending_results.push_back(typed_pending ? typed_result : predicted);
      end
    end
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles = 0;
    end else if (++stall_cycles >= WATCHDOG_LIMIT) begin
      $display("all_pairs_shortest_path_top test failed");
      $finish;
    end
  end

  // Receiver: random back-pressure, or one long hold-off when asked
  initial begin : receiver
    int held;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        for (held = 1; held < HOLD_OFF_CYCLES; held++) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic signed [15:0] pick_weight();
    logic signed [15:0] w;
    case ($urandom_range(9))
      0: w = 16'sh7FFF;
      1: w = 16'sh8000;
      2, 3: w = 16'($urandom);
      4: begin
        w = 16'($urandom_range(20, 1));
        w = -w;
      end
      default: w = 16'($urandom_range(100));
    endcase
    return w;
  endfunction

  // Offer one word, with random idle cycles ahead of it; hold it until taken
  task automatic send_word(input logic [1:0] op, input logic [3:0] row, input logic [3:0] col,
                           input logic signed [15:0] weight, input bit typed = 1'b0,
                           input logic kind = RK_DONE, input logic [15:0] distance = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_row    <= row;
    in_col    <= col;
    in_weight <= weight;
    typed_pending = typed;
    typed_result.kind = kind;
    typed_result.distance = distance;
    if (op == OP_WRITE) written_mask[row][col] = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, drain every expected word, then let the last write retire
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_node_count(input logic [4:0] nodes);
    @(negedge clk);
    cfg_valid      <= 1'b1;
    cfg_node_count <= nodes;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One random phase: unused opcodes, writes, reads of written entries, and, if allowed, runs over a filled block
  task automatic run_phase(input logic [4:0] nodes, input int items,
                           input bit allow_run = 1'b1);
    int span;
    int issued;
    int pick;
    logic [3:0] r;
    logic [3:0] c;
    span = (nodes > NODES) ? NODES : int'(nodes);
    write_node_count(nodes);
    issued = 0;
    while (issued < items) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        send_word(OP_UNUSED, 4'($urandom), 4'($urandom), 16'($urandom));
      end else if (pick < 45) begin
        if (span > 0 && $urandom_range(3) != 0) begin
          r = 4'($urandom_range(span - 1));
          c = 4'($urandom_range(span - 1));
        end else begin
          r = 4'($urandom);
          c = 4'($urandom);
        end
        send_word(OP_WRITE, r, c, pick_weight());
        issued++;
      end else if (pick < 80) begin
        // read only entries that hold a written value
        do begin
          if (span > 0 && $urandom_range(3) != 0) begin
            r = 4'($urandom_range(span - 1));
            c = 4'($urandom_range(span - 1));
          end else begin
            r = 4'($urandom);
            c = 4'($urandom);
          end
        end while (!written_mask[r][c]);
        send_word(OP_READ, r, c, 16'($urandom));
        issued++;
      end else if (allow_run) begin
        // fill the block in use before relaxing over it
        for (int i = 0; i < span; i++) begin
          for (int j = 0; j < span; j++) begin
            if (!written_mask[i][j]) begin
              send_word(OP_WRITE, 4'(i), 4'(j), pick_weight());
              issued++;
            end
          end
        end
        send_word(OP_RUN, 4'($urandom), 4'($urandom), 16'($urandom));
        issued++;
      end
    end
    settle();
  endtask

  initial begin : stimulus
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_node_count = '0;
    in_valid       = 1'b0;
    in_opcode      = OP_WRITE;
    in_row         = '0;
    in_col         = '0;
    in_weight      = '0;
    typed_pending  = 1'b0;
    typed_result   = '0;
    send_idle_pct  = 18;
    recv_idle_pct  = 87;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed script over three nodes
    write_node_count(5'd3);
    foreach (script[s]) begin
      send_word(script[s].op, script[s].row, script[s].col, script[s].weight,
                script[s].typed, script[s].kind, script[s].distance);
    end
    settle();
    run_phase(5'd1, 15);
    run_phase(5'd2, 15);

    // Sender mostly idle, receiver mostly ready
    send_idle_pct = 87;
    recv_idle_pct = 18;
    run_phase(5'd0, 8);
    run_phase(5'd5, 20);
    // full node count: no run words
    run_phase(5'd16, 10, 1'b0);

    // No idling; open with a long receiver hold-off so the input backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_req = 1'b1;
    run_phase(5'd4, 15);
    // saturating node counts: no run words
    run_phase(5'd31, 8, 1'b0);
    run_phase(5'd17, 5, 1'b0);
    run_phase(5'd2, 10);

    if (errors == 0) begin
      $display("all_pairs_shortest_path_top test passed");
    end else begin
      $display("all_pairs_shortest_path_top test failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/apsp_pkg.sv
rtl/core/apsp_ram.sv
rtl/core/all_pairs_shortest_path_top.sv
test/tb.sv
